FILE: sv/ttvg_pkg.sv
// shared types, codes and constant tables of the terrain tile vertex generator
package ttvg_pkg;

  // corner codes, as seen on the corner field
  localparam logic [1:0] CORNER_BL = 2'd0;
  localparam logic [1:0] CORNER_BR = 2'd1;
  localparam logic [1:0] CORNER_TL = 2'd2;
  localparam logic [1:0] CORNER_TR = 2'd3;

  localparam int NUM_CORNERS = 4;
  localparam int ID_W        = 10;
  localparam int SCALE_W     = 6;
  localparam int WORD_W      = 16;
  localparam int LIGHT_W     = 8;
  localparam int SHADE_Q_W   = 6;
  localparam int UV_W        = 23;
  localparam int OUT_POS_W   = 7;

  // a scale field of zero stands for this scale
  localparam logic [SCALE_W-1:0] SCALE_ZERO_MAP = 6'd16;

  // brightness / 5 as (b * 205) >> 10, exact for any 8-bit value
  localparam logic [15:0] SHADE_MUL   = 16'd205;
  localparam int          SHADE_SHIFT = 10;
  localparam logic [7:0]  SHADE_BASE  = 8'd204;

  localparam logic [7:0] ALPHA_ON  = 8'hFF;
  localparam logic [7:0] ALPHA_OFF = 8'h00;

  // vertex sequence within one group of six
  localparam logic [2:0] LAST_VTX = 3'd5;
  localparam logic [1:0] VERT_CORNER [6] = '{CORNER_BL, CORNER_TL, CORNER_BR,
                                             CORNER_BR, CORNER_TL, CORNER_TR};

  // uv source corner, indexed [rotation][corner]
  localparam logic [1:0] ROT_SRC [4][4] = '{
    '{CORNER_BL, CORNER_BR, CORNER_TL, CORNER_TR},
    '{CORNER_TL, CORNER_BL, CORNER_TR, CORNER_BR},
    '{CORNER_TR, CORNER_TL, CORNER_BR, CORNER_BL},
    '{CORNER_BR, CORNER_TR, CORNER_BL, CORNER_TL}
  };

  // reciprocal table: floor(2^32 / s) + 1, so (pos * RECIP[s]) >> 16 is
  // exactly floor(pos * 65536 / s) for any pos up to 256
  localparam int RECIP_W = 33;
  localparam int RECIP_SHIFT = 16;
  localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;
  localparam logic [RECIP_W-1:0] RECIP [64] = '{
    33'(RECIP_NUM / 64'd16 + 64'd1), 33'(RECIP_NUM / 64'd1 + 64'd1),
    33'(RECIP_NUM / 64'd2 + 64'd1),  33'(RECIP_NUM / 64'd3 + 64'd1),
    33'(RECIP_NUM / 64'd4 + 64'd1),  33'(RECIP_NUM / 64'd5 + 64'd1),
    33'(RECIP_NUM / 64'd6 + 64'd1),  33'(RECIP_NUM / 64'd7 + 64'd1),
    33'(RECIP_NUM / 64'd8 + 64'd1),  33'(RECIP_NUM / 64'd9 + 64'd1),
    33'(RECIP_NUM / 64'd10 + 64'd1), 33'(RECIP_NUM / 64'd11 + 64'd1),
    33'(RECIP_NUM / 64'd12 + 64'd1), 33'(RECIP_NUM / 64'd13 + 64'd1),
    33'(RECIP_NUM / 64'd14 + 64'd1), 33'(RECIP_NUM / 64'd15 + 64'd1),
    33'(RECIP_NUM / 64'd16 + 64'd1), 33'(RECIP_NUM / 64'd17 + 64'd1),
    33'(RECIP_NUM / 64'd18 + 64'd1), 33'(RECIP_NUM / 64'd19 + 64'd1),
    33'(RECIP_NUM / 64'd20 + 64'd1), 33'(RECIP_NUM / 64'd21 + 64'd1),
    33'(RECIP_NUM / 64'd22 + 64'd1), 33'(RECIP_NUM / 64'd23 + 64'd1),
    33'(RECIP_NUM / 64'd24 + 64'd1), 33'(RECIP_NUM / 64'd25 + 64'd1),
    33'(RECIP_NUM / 64'd26 + 64'd1), 33'(RECIP_NUM / 64'd27 + 64'd1),
    33'(RECIP_NUM / 64'd28 + 64'd1), 33'(RECIP_NUM / 64'd29 + 64'd1),
    33'(RECIP_NUM / 64'd30 + 64'd1), 33'(RECIP_NUM / 64'd31 + 64'd1),
    33'(RECIP_NUM / 64'd32 + 64'd1), 33'(RECIP_NUM / 64'd33 + 64'd1),
    33'(RECIP_NUM / 64'd34 + 64'd1), 33'(RECIP_NUM / 64'd35 + 64'd1),
    33'(RECIP_NUM / 64'd36 + 64'd1), 33'(RECIP_NUM / 64'd37 + 64'd1),
    33'(RECIP_NUM / 64'd38 + 64'd1), 33'(RECIP_NUM / 64'd39 + 64'd1),
    33'(RECIP_NUM / 64'd40 + 64'd1), 33'(RECIP_NUM / 64'd41 + 64'd1),
    33'(RECIP_NUM / 64'd42 + 64'd1), 33'(RECIP_NUM / 64'd43 + 64'd1),
    33'(RECIP_NUM / 64'd44 + 64'd1), 33'(RECIP_NUM / 64'd45 + 64'd1),
    33'(RECIP_NUM / 64'd46 + 64'd1), 33'(RECIP_NUM / 64'd47 + 64'd1),
    33'(RECIP_NUM / 64'd48 + 64'd1), 33'(RECIP_NUM / 64'd49 + 64'd1),
    33'(RECIP_NUM / 64'd50 + 64'd1), 33'(RECIP_NUM / 64'd51 + 64'd1),
    33'(RECIP_NUM / 64'd52 + 64'd1), 33'(RECIP_NUM / 64'd53 + 64'd1),
    33'(RECIP_NUM / 64'd54 + 64'd1), 33'(RECIP_NUM / 64'd55 + 64'd1),
    33'(RECIP_NUM / 64'd56 + 64'd1), 33'(RECIP_NUM / 64'd57 + 64'd1),
    33'(RECIP_NUM / 64'd58 + 64'd1), 33'(RECIP_NUM / 64'd59 + 64'd1),
    33'(RECIP_NUM / 64'd60 + 64'd1), 33'(RECIP_NUM / 64'd61 + 64'd1),
    33'(RECIP_NUM / 64'd62 + 64'd1), 33'(RECIP_NUM / 64'd63 + 64'd1)
  };

  // classified tile as it travels from the front to the back
  typedef struct packed {
    logic [NUM_CORNERS-1:0][ID_W-1:0]      ids;
    logic [NUM_CORNERS-1:0][SHADE_Q_W-1:0] shade_q;
    logic [1:0]                            rot;
    logic [1:0]                            blend_cnt;
    logic [NUM_CORNERS-1:0][ID_W-1:0]      grp_id;
    logic [NUM_CORNERS-1:0][SCALE_W-1:0]   grp_scale;
  } tile_cls_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

FILE: sv/ttvg_front.sv
// front: accepts a tile, normalizes it and builds the sorted blend group list
module ttvg_front #(
  parameter int TILE_GRID = 96,
  parameter int POS_W     = 7
) (
  input  logic                                                  in_valid,
  output logic                                                  in_ready,
  input  logic [ttvg_pkg::NUM_CORNERS-1:0][ttvg_pkg::WORD_W-1:0]  word,
  input  logic [ttvg_pkg::NUM_CORNERS-1:0][ttvg_pkg::LIGHT_W-1:0] light,
  input  logic [1:0]                                            rotation,
  input  logic [6:0]                                            tile_col,
  input  logic [6:0]                                            tile_row,
  input  logic                                                  q_full,
  output logic                                                  push,
  output ttvg_pkg::tile_cls_t                                   cls,
  output logic [POS_W-1:0]                                      col,
  output logic [POS_W-1:0]                                      row
);

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(TILE_GRID - 1);

  logic [ttvg_pkg::NUM_CORNERS-1:0][ttvg_pkg::ID_W-1:0]    ids;
  logic [ttvg_pkg::NUM_CORNERS-1:0][ttvg_pkg::SCALE_W-1:0] scales;
  logic [3:1]       cand_ok;
  logic [3:1][1:0]  rank;
  logic [15:0]      shade_prod [ttvg_pkg::NUM_CORNERS];

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    if (32'(tile_col) > TILE_GRID - 1) col = POS_MAX;
    else col = POS_W'(tile_col);
    if (32'(tile_row) > TILE_GRID - 1) row = POS_MAX;
    else row = POS_W'(tile_row);
  end

  always_comb begin
    for (int i = 0; i < ttvg_pkg::NUM_CORNERS; i++) begin
      ids[i] = word[i][ttvg_pkg::ID_W-1:0];
      scales[i] = word[i][ttvg_pkg::WORD_W-1:ttvg_pkg::ID_W];
      if (scales[i] == '0) scales[i] = ttvg_pkg::SCALE_ZERO_MAP;
      shade_prod[i] = 16'(light[i]) * ttvg_pkg::SHADE_MUL;
    end
  end

  // a blend candidate differs from bl and from every earlier candidate
  always_comb begin
    cand_ok[1] = ids[1] != ids[0];
    cand_ok[2] = (ids[2] != ids[0]) && (ids[2] != ids[1]);
    cand_ok[3] = (ids[3] != ids[0]) && (ids[3] != ids[1]) && (ids[3] != ids[2]);
  end

  // rank = number of surviving candidates with a smaller id
  always_comb begin
    for (int i = 1; i < 4; i++) begin
      rank[i] = '0;
      for (int k = 1; k < 4; k++) begin
        if (k != i && cand_ok[k] && ids[k] < ids[i]) rank[i] = rank[i] + 2'd1;
      end
    end
  end

  always_comb begin
    cls.ids = ids;
    cls.rot = rotation;
    cls.blend_cnt = 2'(cand_ok[1]) + 2'(cand_ok[2]) + 2'(cand_ok[3]);
    for (int i = 0; i < ttvg_pkg::NUM_CORNERS; i++) begin
      cls.shade_q[i] = ttvg_pkg::SHADE_Q_W'(shade_prod[i] >> ttvg_pkg::SHADE_SHIFT);
      cls.grp_id[i] = '0;
      cls.grp_scale[i] = ttvg_pkg::SCALE_ZERO_MAP;
    end
    cls.grp_id[0] = ids[0];
    cls.grp_scale[0] = scales[0];
    for (int i = 1; i < 4; i++) begin
      if (cand_ok[i]) begin
        cls.grp_id[2'(rank[i] + 2'd1)] = ids[i];
        cls.grp_scale[2'(rank[i] + 2'd1)] = scales[i];
      end
    end
  end

endmodule

FILE: sv/ttvg_queue.sv
// short fifo between the front and the back
module ttvg_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = $clog2(ttvg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ttvg_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ttvg_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [ttvg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == DEPTH_C;
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (32'(wr_ptr) == ttvg_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (32'(rd_ptr) == ttvg_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: sv/ttvg_back.sv
// back: walks the groups of a tile and emits one vertex per cycle while the output is not stalled
module ttvg_back #(
  parameter int POS_W = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  ttvg_pkg::tile_cls_t       q_cls,
  input  logic [POS_W-1:0]          q_col,
  input  logic [POS_W-1:0]          q_row,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_blend,
  output logic [ttvg_pkg::ID_W-1:0] out_tex_id,
  output logic [1:0]                out_corner,
  output logic [6:0]                out_grid_x,
  output logic [6:0]                out_grid_z,
  output logic [ttvg_pkg::UV_W-1:0] out_tex_u,
  output logic [ttvg_pkg::UV_W-1:0] out_tex_v,
  output logic [7:0]                out_shade,
  output logic [7:0]                out_alpha,
  output logic                      out_last
);

  localparam int PROD_W = POS_W + ttvg_pkg::RECIP_W;

  logic       adv;
  logic       issue;
  logic [2:0] vtx;
  logic [1:0] grp;
  logic       grp_done;
  logic       tile_done;

  logic [1:0]                     c_sel;
  logic [1:0]                     s_sel;
  logic [ttvg_pkg::ID_W-1:0]      tex_sel;
  logic [ttvg_pkg::SCALE_W-1:0]   scale_sel;

  logic                           a_valid;
  logic                           a_blend;
  logic [ttvg_pkg::ID_W-1:0]      a_tex_id;
  logic [1:0]                     a_corner;
  logic [6:0]                     a_grid_x;
  logic [6:0]                     a_grid_z;
  logic [POS_W-1:0]               a_sx;
  logic [POS_W-1:0]               a_sz;
  logic [ttvg_pkg::RECIP_W-1:0]   a_recip;
  logic [7:0]                     a_shade;
  logic [7:0]                     a_alpha;
  logic                           a_last;
  logic [PROD_W-1:0]              prod_u;
  logic [PROD_W-1:0]              prod_v;

  // whole pipe moves when the output register is free or being taken
  assign adv       = !out_valid || out_ready;
  assign issue     = q_valid && adv;
  assign grp_done  = vtx == ttvg_pkg::LAST_VTX;
  assign tile_done = grp_done && (grp == q_cls.blend_cnt);
  assign q_pop     = issue && tile_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx <= '0;
      grp <= '0;
    end else if (issue) begin
      if (grp_done) begin
        vtx <= '0;
        grp <= tile_done ? 2'd0 : grp + 2'd1;
      end else begin
        vtx <= vtx + 3'd1;
      end
    end
  end

  always_comb begin
    c_sel     = ttvg_pkg::VERT_CORNER[vtx];
    s_sel     = ttvg_pkg::ROT_SRC[q_cls.rot][c_sel];
    tex_sel   = q_cls.grp_id[grp];
    scale_sel = q_cls.grp_scale[grp];
  end

  // stage a: vertex selection and table lookups
  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= issue;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_blend  <= grp != 2'd0;
      a_tex_id <= tex_sel;
      a_corner <= c_sel;
      a_grid_x <= 7'(q_col + POS_W'(c_sel[0]));
      a_grid_z <= 7'(q_row + POS_W'(c_sel[1]));
      a_sx     <= q_col + POS_W'(s_sel[0]);
      a_sz     <= q_row + POS_W'(s_sel[1]);
      a_recip  <= ttvg_pkg::RECIP[scale_sel];
      a_shade  <= ttvg_pkg::SHADE_BASE + 8'(q_cls.shade_q[c_sel]);
      a_alpha  <= (grp == 2'd0 || q_cls.ids[c_sel] == tex_sel) ?
                  ttvg_pkg::ALPHA_ON : ttvg_pkg::ALPHA_OFF;
      a_last   <= tile_done;
    end
  end

  // stage b: pos * reciprocal, then the fixed shift
  assign prod_u = PROD_W'(a_sx) * PROD_W'(a_recip);
  assign prod_v = PROD_W'(a_sz) * PROD_W'(a_recip);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blend  <= a_blend;
      out_tex_id <= a_tex_id;
      out_corner <= a_corner;
      out_grid_x <= a_grid_x;
      out_grid_z <= a_grid_z;
      out_tex_u  <= ttvg_pkg::UV_W'(prod_u >> ttvg_pkg::RECIP_SHIFT);
      out_tex_v  <= ttvg_pkg::UV_W'(prod_v >> ttvg_pkg::RECIP_SHIFT);
      out_shade  <= a_shade;
      out_alpha  <= a_alpha;
      out_last   <= a_last;
    end
  end

  a_bl_blend_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_blend && out_corner == ttvg_pkg::CORNER_BL
      |-> out_alpha == ttvg_pkg::ALPHA_OFF)
    else $error("blend vertex at bl corner is not transparent");

  a_base_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_blend |-> out_alpha == ttvg_pkg::ALPHA_ON)
    else $error("base vertex is not opaque");

  a_pop_at_group_end: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && vtx == ttvg_pkg::LAST_VTX)
    else $error("tile released before its last vertex");

  a_last_closes_tile: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> a_valid && a_last && vtx == 3'd0 && grp == 2'd0)
    else $error("tile end not marked or counters not rewound");

endmodule

FILE: sv/terrain_tile_vertex_generator_core.sv
// top level of the terrain tile vertex generator
// path: tiles wait in the queue, vertices pass the stage a and output registers
// throughput: one vertex per cycle while the output is not stalled; a tile gives
//   6 * (1 + distinct blend ids) vertices, 6 to 24, from the back sequencer
// a two-entry queue lets new tiles be taken while the back still emits earlier ones
// reset: synchronous, clears the queue, the group/vertex counters and all valid bits
module terrain_tile_vertex_generator_core #(
  parameter int TILE_GRID = 96
) (
  input  logic          clk,
  input  logic          rst,
  // tile input
  input  logic          s_tvalid,
  output logic          s_tready,
  // word_bl[15:0] word_br[31:16] word_tl[47:32] word_tr[63:48]
  // light_bl[71:64] light_br[79:72] light_tl[87:80] light_tr[95:88]
  // rotation[97:96] tile_col[104:98] tile_row[111:105]
  input  logic [111:0]  s_tdata,
  // vertex output
  output logic          m_tvalid,
  input  logic          m_tready,
  // texture_id[9:0] corner[11:10] grid_x[18:12] grid_z[25:19] tex_u[48:26]
  // tex_v[71:49] shade[79:72] alpha[87:80]
  output logic [87:0]   m_tdata,
  // blend_pass[0]
  output logic          m_tuser,
  // last vertex of the tile
  output logic          m_tlast
);

  // wide enough to hold TILE_GRID itself (right/top edge of the last tile)
  localparam int POS_W = $clog2(TILE_GRID + 1);
  localparam int Q_W   = $bits(ttvg_pkg::tile_cls_t) + 2 * POS_W;

  logic [ttvg_pkg::NUM_CORNERS-1:0][ttvg_pkg::WORD_W-1:0]  word;
  logic [ttvg_pkg::NUM_CORNERS-1:0][ttvg_pkg::LIGHT_W-1:0] light;

  logic                      push;
  logic                      q_full;
  ttvg_pkg::tile_cls_t       f_cls;
  logic [POS_W-1:0]          f_col;
  logic [POS_W-1:0]          f_row;

  logic                      q_pop;
  logic                      q_valid;
  logic [Q_W-1:0]            q_data;
  ttvg_pkg::tile_cls_t       q_cls;
  logic [POS_W-1:0]          q_col;
  logic [POS_W-1:0]          q_row;

  logic [ttvg_pkg::ID_W-1:0] tex_id;
  logic [1:0]                corner;
  logic [6:0]                grid_x;
  logic [6:0]                grid_z;
  logic [ttvg_pkg::UV_W-1:0] tex_u;
  logic [ttvg_pkg::UV_W-1:0] tex_v;
  logic [7:0]                shade;
  logic [7:0]                alpha;

  // unpack the tile transaction, corner order bl, br, tl, tr
  assign word[0]  = s_tdata[15:0];
  assign word[1]  = s_tdata[31:16];
  assign word[2]  = s_tdata[47:32];
  assign word[3]  = s_tdata[63:48];
  assign light[0] = s_tdata[71:64];
  assign light[1] = s_tdata[79:72];
  assign light[2] = s_tdata[87:80];
  assign light[3] = s_tdata[95:88];

  // front: saturates position, splits words, dedups and sorts blend ids
  ttvg_front #(
    .TILE_GRID (TILE_GRID),
    .POS_W     (POS_W)
  ) u_front (
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .word      (word),
    .light     (light),
    .rotation  (s_tdata[97:96]),
    .tile_col  (s_tdata[104:98]),
    .tile_row  (s_tdata[111:105]),
    .q_full    (q_full),
    .push      (push),
    .cls       (f_cls),
    .col       (f_col),
    .row       (f_row)
  );

  // one entry per classified tile
  ttvg_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({f_col, f_row, f_cls}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  assign {q_col, q_row, q_cls} = q_data;

  // back: base group then blend groups, six vertices each
  ttvg_back #(
    .POS_W (POS_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cls      (q_cls),
    .q_col      (q_col),
    .q_row      (q_row),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_blend  (m_tuser),
    .out_tex_id (tex_id),
    .out_corner (corner),
    .out_grid_x (grid_x),
    .out_grid_z (grid_z),
    .out_tex_u  (tex_u),
    .out_tex_v  (tex_v),
    .out_shade  (shade),
    .out_alpha  (alpha),
    .out_last   (m_tlast)
  );

  // pack the vertex transaction
  assign m_tdata = {alpha, shade, tex_v, tex_u, grid_z, grid_x, corner, tex_id};

endmodule

FILE: tb/sv/testbench.sv
// self-checking bench for the terrain tile vertex generator, scored per vertex
`timescale 1ns / 1ps

module testbench;

  localparam int TILE_GRID    = 96;
  localparam int CLK_HALF_NS  = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_TILES = 352;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYCLES = 40;

  // one tile as it sits on s_tdata, corner index 0 BL, 1 BR, 2 TL, 3 TR
  typedef struct packed {
    logic [6:0]       tile_row;
    logic [6:0]       tile_col;
    logic [1:0]       rotation;
    logic [3:0][7:0]  light;
    logic [3:0][15:0] word;
  } tile_t;

  // one vertex as {m_tuser, m_tlast, m_tdata}
  typedef struct packed {
    logic        blend_pass;
    logic        last;
    logic [7:0]  alpha;
    logic [7:0]  shade;
    logic [22:0] tex_v;
    logic [22:0] tex_u;
    logic [6:0]  grid_z;
    logic [6:0]  grid_x;
    logic [1:0]  corner;
    logic [9:0]  texture_id;
  } vertex_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  // corner walked by each of the six vertices of a group
  localparam logic [1:0] TRI_CORNER [6] = '{ttvg_pkg::CORNER_BL, ttvg_pkg::CORNER_TL,
                                            ttvg_pkg::CORNER_BR, ttvg_pkg::CORNER_BR,
                                            ttvg_pkg::CORNER_TL, ttvg_pkg::CORNER_TR};
  // corner whose position feeds the uv, by [rotation][corner]
  localparam logic [1:0] UV_FROM [4][4] = '{
    '{ttvg_pkg::CORNER_BL, ttvg_pkg::CORNER_BR, ttvg_pkg::CORNER_TL, ttvg_pkg::CORNER_TR},
    '{ttvg_pkg::CORNER_TL, ttvg_pkg::CORNER_BL, ttvg_pkg::CORNER_TR, ttvg_pkg::CORNER_BR},
    '{ttvg_pkg::CORNER_TR, ttvg_pkg::CORNER_TL, ttvg_pkg::CORNER_BR, ttvg_pkg::CORNER_BL},
    '{ttvg_pkg::CORNER_BR, ttvg_pkg::CORNER_TR, ttvg_pkg::CORNER_BL, ttvg_pkg::CORNER_TL}
  };

  // expands each accepted tile into its vertex list and scores the output
  class vertex_checker;
    vertex_t    expected_vertices[$];
    int         errors;
    logic [9:0] cur_id [4];
    int         cur_light [4];
    int         cur_col;
    int         cur_row;
    int         cur_rot;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction

    function void add_group(bit blend, logic [9:0] gid, int scale, bit final_group);
      vertex_t    vx;
      logic [1:0] c;
      logic [1:0] s;
      int         sx;
      int         sz;
      for (int v = 0; v < 6; v++) begin
        c  = TRI_CORNER[v];
        s  = UV_FROM[cur_rot][c];
        sx = cur_col + s[0];
        sz = cur_row + s[1];
        vx.blend_pass = blend;
        vx.texture_id = gid;
        vx.corner     = c;
        vx.grid_x     = 7'(cur_col + c[0]);
        vx.grid_z     = 7'(cur_row + c[1]);
        vx.tex_u      = 23'((sx << 16) / scale);
        vx.tex_v      = 23'((sz << 16) / scale);
        vx.shade      = 8'(204 + cur_light[c] / 5);
        vx.alpha      = (!blend || cur_id[c] == gid) ? 8'd255 : 8'd0;
        vx.last       = final_group && (v == 5);
        expected_vertices.insert(expected_vertices.size(), vx);
      end
    endfunction

    function void add_tile(tile_t t);
      int         scale [4];
      logic [9:0] blend_id [3];
      logic [9:0] swap_id;
      int         n_blend;
      bit         seen;
      int         sc;
      n_blend = 0;
      for (int c = 0; c < 4; c++) begin
        cur_id[c]    = t.word[c][9:0];
        scale[c]     = (t.word[c][15:10] == 6'd0) ? 16 : int'(t.word[c][15:10]);
        cur_light[c] = t.light[c];
      end
      cur_rot = t.rotation;
      cur_col = (t.tile_col > TILE_GRID - 1) ? TILE_GRID - 1 : int'(t.tile_col);
      cur_row = (t.tile_row > TILE_GRID - 1) ? TILE_GRID - 1 : int'(t.tile_row);
      // distinct ids other than the bottom-left one, ascending
      for (int c = 1; c < 4; c++) begin
        seen = (cur_id[c] == cur_id[0]);
        for (int k = 0; k < n_blend; k++)
          if (blend_id[k] == cur_id[c]) seen = 1'b1;
        if (!seen) begin
          blend_id[n_blend] = cur_id[c];
          n_blend++;
        end
      end
      for (int i = 0; i < n_blend; i++)
        for (int j = 0; j < n_blend - 1 - i; j++)
          if (blend_id[j] > blend_id[j + 1]) begin
            swap_id         = blend_id[j];
            blend_id[j]     = blend_id[j + 1];
            blend_id[j + 1] = swap_id;
          end
      add_group(1'b0, cur_id[0], scale[0], n_blend == 0);
      for (int k = 0; k < n_blend; k++) begin
        // scale of the first of BR, TL, TR carrying this id
        if (cur_id[1] == blend_id[k]) sc = scale[1];
        else if (cur_id[2] == blend_id[k]) sc = scale[2];
        else sc = scale[3];
        add_group(1'b1, blend_id[k], sc, k == n_blend - 1);
      end
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_vx;
      if (expected_vertices.size() == 0) begin
        $error("vertex with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_vx = expected_vertices.pop_front();
      compare_field("blend_pass", exp_vx.blend_pass, got.blend_pass);
      compare_field("texture_id", exp_vx.texture_id, got.texture_id);
      compare_field("corner", exp_vx.corner, got.corner);
      compare_field("grid_x", exp_vx.grid_x, got.grid_x);
      compare_field("grid_z", exp_vx.grid_z, got.grid_z);
      compare_field("tex_u", exp_vx.tex_u, got.tex_u);
      compare_field("tex_v", exp_vx.tex_v, got.tex_v);
      compare_field("shade", exp_vx.shade, got.shade);
      compare_field("alpha", exp_vx.alpha, got.alpha);
      compare_field("last", exp_vx.last, got.last);
    endfunction
  endclass

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  vertex_checker chk = new();

  // sender bookkeeping: valid is only written when it changes
  bit offering   = 1'b0;
  int burst_left = 0;

  // receiver bookkeeping
  bit       hold_request = 1'b0;
  int       hold_left    = 0;
  int       mode_left    = 0;
  int       rx_phase     = 0;
  rx_mode_t rx_mode      = RX_FREE;

  int cycle_count = 0;

  terrain_tile_vertex_generator_core #(
    .TILE_GRID(TILE_GRID)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #CLK_HALF_NS clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // output side: a long hold-off on request, otherwise a stall pattern that
  // switches between free-running, light, periodic and heavy back-pressure
  always @(posedge clk) begin
    rx_phase++;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:     m_tready <= 1'b1;
        RX_LIGHT:    m_tready <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: m_tready <= (rx_phase % 3 == 0);
        default:     m_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // score every vertex transaction; values read here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      chk.check_vertex(vertex_t'({m_tuser, m_tlast, m_tdata}));
  end

  function automatic logic [15:0] tex_word(int id, int scale);
    return {6'(scale), 10'(id)};
  endfunction

  // lights packed {tr, tl, br, bl}
  function automatic tile_t make_tile(logic [15:0] bl, logic [15:0] br, logic [15:0] tl,
                                      logic [15:0] tr, logic [31:0] lights, int rot,
                                      int col, int row);
    tile_t t;
    t.word     = {tr, tl, br, bl};
    t.light    = lights;
    t.rotation = 2'(rot);
    t.tile_col = 7'(col);
    t.tile_row = 7'(row);
    return t;
  endfunction

  // ids mostly drawn from a small pool so equal corners and blend groups are common
  function automatic tile_t random_tile();
    tile_t      t;
    logic [9:0] id_pool [4];
    int         pool_size;
    bit         pooled;
    int         scale;
    pooled    = ($urandom_range(0, 9) < 7);
    pool_size = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 7))
        0:       id_pool[k] = 10'd0;
        1:       id_pool[k] = 10'h3FF;
        default: id_pool[k] = 10'($urandom);
      endcase
    end
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 7))
        0:       scale = 0;
        1:       scale = 1;
        default: scale = $urandom_range(0, 63);
      endcase
      if (pooled)
        t.word[c] = tex_word(id_pool[$urandom_range(0, pool_size - 1)], scale);
      else
        t.word[c] = 16'($urandom);
    end
    t.light    = $urandom;
    t.rotation = 2'($urandom_range(0, 3));
    // occasionally past the grid edge to hit saturation
    t.tile_col = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(96, 127))
                                             : 7'($urandom_range(0, 95));
    t.tile_row = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(96, 127))
                                             : 7'($urandom_range(0, 95));
    return t;
  endfunction

  task automatic pause_sender(input int cycles);
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
    repeat (cycles) @(posedge clk);
  endtask

  // offer one tile, hold it until the transaction, then maybe start a gap
  task automatic offer_tile(input tile_t t);
    s_tdata <= t;
    if (!offering) begin
      s_tvalid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (!s_tready);
    chk.add_tile(t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_sender($urandom_range(1, 10));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_all_vertices();
    pause_sender(0);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, scale zero, saturation
    offer_tile(make_tile(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 0, 0, 0));
    offer_tile(make_tile(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 3,
                         127, 127));
    // four distinct ids under every rotation
    for (int r = 0; r < 4; r++)
      offer_tile(make_tile(tex_word(500, 1), tex_word(3, 5), tex_word(1023, 0),
                           tex_word(7, 63), 32'hFFFE_0504, r, 95 - r, r));
    // blend ids below the bottom-left id, duplicate takes the first scale
    offer_tile(make_tile(tex_word(900, 2), tex_word(10, 3), tex_word(10, 7),
                         tex_word(20, 9), 32'h0405_FEFF, 1, 40, 60));
    // bottom-right equals bottom-left, top pair shares an id
    offer_tile(make_tile(tex_word(5, 4), tex_word(5, 9), tex_word(6, 11),
                         tex_word(6, 13), 32'h1234_5678, 2, 12, 90));
    // only top-right differs
    offer_tile(make_tile(tex_word(77, 0), tex_word(77, 1), tex_word(77, 2),
                         tex_word(76, 0), 32'h0000_00FF, 0, 95, 95));
    // three corners share one id different from bottom-left
    offer_tile(make_tile(tex_word(0, 63), tex_word(1023, 1), tex_word(1023, 8),
                         tex_word(1023, 40), 32'hFF00_FF00, 3, 0, 95));
    // top-left id matches bottom-right: scale comes from bottom-right
    offer_tile(make_tile(tex_word(300, 6), tex_word(200, 0), tex_word(200, 33),
                         tex_word(301, 17), 32'h0105_0A0F, 1, 95, 0));
    // position saturation on each axis
    offer_tile(make_tile(tex_word(1, 1), tex_word(2, 1), tex_word(3, 1),
                         tex_word(4, 1), 32'h0, 0, 96, 0));
    offer_tile(make_tile(tex_word(1, 1), tex_word(1, 1), tex_word(1, 1),
                         tex_word(1, 1), 32'hFFFF_FFFF, 2, 0, 96));
    offer_tile(make_tile(tex_word(512, 0), tex_word(511, 63), tex_word(512, 1),
                         tex_word(511, 2), 32'h0405_0405, 1, 127, 95));
    wait_all_vertices();

    for (int n = 0; n < RANDOM_TILES; n++) begin
      // long output hold-off while tiles keep coming, so the input stalls
      if (n == 100 || n == 260) begin
        hold_request = 1'b1;
        burst_left   = 40;
      end
      // sender waits for the output to empty out completely
      if (n == 180) wait_all_vertices();
      offer_tile(random_tile());
    end

    wait_all_vertices();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chk.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ttvg_pkg.sv
sv/ttvg_front.sv
sv/ttvg_queue.sv
sv/ttvg_back.sv
sv/terrain_tile_vertex_generator_core.sv
tb/sv/testbench.sv
